// ----- hdl/assert_macros.svh -----
// Assertion macros for the RTL of the LRU page replacement block.
// Needs nothing else; synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- hdl/lrup_pkg.sv -----
// Package for the LRU page replacement block: operation codes and status flags.
// No dependencies.
`timescale 1ns / 1ps
package lrup_pkg;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_ACCESS = 2'd1,
    MODE_EVICT  = 2'd2
  } lrup_mode_t;

  typedef struct packed {
    logic victim_valid;
    logic hit;
    logic overflow;
  } lrup_flags_t;

endpackage

// ----- hdl/lrup_req_if.sv -----
// Request channel of the LRU page replacement block: valid/ready plus payload.
// No dependencies.
`timescale 1ns / 1ps
interface lrup_req_if #(
  parameter int PAGE_BITS = 20
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic [PAGE_BITS-1:0] page_number;

  modport source (output valid, mode, page_number, input ready);
  modport sink   (input valid, mode, page_number, output ready);
endinterface

// ----- hdl/lrup_rsp_if.sv -----
// Result channel of the LRU page replacement block: valid/ready plus payload.
// No dependencies.
`timescale 1ns / 1ps
interface lrup_rsp_if #(
  parameter int PAGE_BITS = 20
);
  logic                 valid;
  logic                 ready;
  logic                 victim_valid;
  logic [PAGE_BITS-1:0] victim_page;
  logic                 hit;
  logic                 overflow;

  modport source (output valid, victim_valid, victim_page, hit, overflow, input ready);
  modport sink   (input valid, victim_valid, victim_page, hit, overflow, output ready);
endinterface

// ----- hdl/lrup_stack.sv -----
// Recency stack: page slots, entry count, parallel lookup and shift update.
// Depends on lrup_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lrup_stack
  import lrup_pkg::*;
#(
  parameter int DEPTH     = 8,
  parameter int PAGE_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 op_valid,
  input  logic [1:0]           op_mode,
  input  logic [PAGE_BITS-1:0] op_page,
  output lrup_flags_t          flags,
  output logic [PAGE_BITS-1:0] victim_page
);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [PAGE_BITS-1:0] entries [DEPTH];
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [DEPTH-1:0]     match;
  logic [IDX_W-1:0]     idx;
  logic                 hit_any;
  logic                 full;
  logic                 empty;
  logic                 do_promote;
  logic                 do_append;
  logic                 do_evict;

  // Compare every live slot at once; resident pages are unique.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = (CNT_W'(i) < count) && (entries[i] == op_page);
    end
  end

  always_comb begin
    idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
  end

  assign hit_any = |match;
  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);

  always_comb begin
    do_promote = 1'b0;
    do_append  = 1'b0;
    do_evict   = 1'b0;
    flags      = '0;
    unique case (op_mode)
      MODE_INSERT: begin
        if (hit_any) begin
          do_promote = 1'b1;
          flags.hit  = 1'b1;
        end else if (full) begin
          flags.overflow = 1'b1;
        end else begin
          do_append = 1'b1;
        end
      end
      MODE_ACCESS: begin
        if (hit_any) begin
          do_promote = 1'b1;
          flags.hit  = 1'b1;
        end
      end
      MODE_EVICT: begin
        if (!empty) begin
          do_evict           = 1'b1;
          flags.victim_valid = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign victim_page = do_evict ? entries[0] : '0;

  always_comb begin
    count_next = count;
    if (op_valid && do_append) begin
      count_next = count + CNT_W'(1);
    end else if (op_valid && do_evict) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Each slot takes its younger neighbor on a shift, or the page itself.
  for (genvar g = 0; g < DEPTH; g++) begin : g_slot
    if (g < DEPTH - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (op_valid) begin
          if (do_evict) begin
            entries[g] <= entries[g+1];
          end else if (do_promote) begin
            if (CNT_W'(g) == count - CNT_W'(1)) begin
              entries[g] <= op_page;
            end else if (IDX_W'(g) >= idx && CNT_W'(g + 1) < count) begin
              entries[g] <= entries[g+1];
            end
          end else if (do_append && CNT_W'(g) == count) begin
            entries[g] <= op_page;
          end
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (op_valid) begin
          if (do_promote && CNT_W'(g) == count - CNT_W'(1)) begin
            entries[g] <= op_page;
          end else if (do_append && CNT_W'(g) == count) begin
            entries[g] <= op_page;
          end
        end
      end
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(DEPTH), "entry count above depth")
  `ASSERT_ALWAYS(a_unique_page, clk, rst, $onehot0(match), "page resident in two slots")
  `ASSERT_NEXT(a_evict_dec, clk, rst, op_valid && do_evict,
               count == $past(count) - CNT_W'(1), "evict did not drop one entry")
endmodule

// ----- hdl/lru_page_replacement.sv -----
// Top level of the LRU page replacement block: request register, recency stack,
// result register. Depends on lrup_pkg, lrup_req_if, lrup_rsp_if, lrup_stack.
//
// Usage:
//   req carries mode (insert, access, evict) and page_number; rsp returns one
//   result per request: victim_valid/victim_page for evict, hit for an access
//   or an insert of a resident page, overflow for a new page into a full list.
//   Both channels move a request or result when valid and ready are high.
//   The accepting edge loads the request register; the stack does its lookup
//   and update from it, and the result register, which drives rsp.valid,
//   loads from the stack once the result slot is free.
//   Throughput: one request per cycle while the receiver keeps rsp.ready
//   high; the lookup over all DEPTH slots is combinational and the shift
//   update is registered.
//   Reset (rst, synchronous) empties the list and drops anything in flight.
//   When the receiver stalls, the result register holds, the request register
//   fills behind it, and req.ready falls until rsp.ready returns.
`timescale 1ns / 1ps
module lru_page_replacement
  import lrup_pkg::*;
#(
  parameter int DEPTH     = 8,
  parameter int PAGE_BITS = 20
) (
  input  logic clk,
  input  logic rst,
  lrup_req_if.sink   req,
  lrup_rsp_if.source rsp
);
  // Request register stage.
  logic                 s1_valid;
  logic [1:0]           s1_mode;
  logic [PAGE_BITS-1:0] s1_page;

  // Result register stage.
  logic                 out_valid;
  lrup_flags_t          out_flags;
  logic [PAGE_BITS-1:0] out_page;

  lrup_flags_t          stk_flags;
  logic [PAGE_BITS-1:0] stk_victim;
  logic                 out_free;
  logic                 s1_fire;

  // Advance the request into the stack only when the result slot can take it.
  assign out_free  = !out_valid || rsp.ready;
  assign s1_fire   = s1_valid && out_free;
  assign req.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_mode <= req.mode;
      s1_page <= req.page_number;
    end
  end

  lrup_stack #(
    .DEPTH     (DEPTH),
    .PAGE_BITS (PAGE_BITS)
  ) u_stack (
    .clk         (clk),
    .rst         (rst),
    .op_valid    (s1_fire),
    .op_mode     (s1_mode),
    .op_page     (s1_page),
    .flags       (stk_flags),
    .victim_page (stk_victim)
  );

  // Hold the result until taken; load a fresh one whenever the stack fires.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_flags <= stk_flags;
      out_page  <= stk_victim;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.victim_valid = out_flags.victim_valid;
  assign rsp.victim_page  = out_page;
  assign rsp.hit          = out_flags.hit;
  assign rsp.overflow     = out_flags.overflow;
endmodule
